FILE: rtl/wsh_pkg.sv
`timescale 1ns / 1ps

package wsh_pkg;

    localparam int MAX_SIZE_BYTES = 5;
    localparam int CNT_W          = $clog2(MAX_SIZE_BYTES + 1);
    localparam int LEB_BITS       = 7;
    localparam int SH_W           = $clog2(LEB_BITS * MAX_SIZE_BYTES);
    localparam int POS_W          = 24;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 24;

    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
    localparam logic [7:0]       WANTED_RESET = 8'd1;
    localparam logic [POS_W-1:0] LIMIT_RESET  = POS_W'(1024 * 1000);

    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_SECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_LIMIT   = 2'd1;

    localparam logic [7:0] MAGIC [4] = '{8'h00, 8'h61, 8'h73, 8'h6d};

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_VERSION,
        PH_ID,
        PH_SIZE,
        PH_SKIP,
        PH_STOP
    } wsh_phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER       = 2'd0,
        KIND_BAD_MAGIC    = 2'd1,
        KIND_SIZE_TOO_LONG = 2'd2
    } wsh_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_module;
    } wsh_item_t;

    typedef struct packed {
        wsh_kind_t        report_kind;
        logic [7:0]       section_id;
        logic [31:0]      section_size;
        logic [POS_W-1:0] header_offset;
        logic [POS_W-1:0] content_offset;
        logic             is_wanted;
        logic [31:0]      module_version;
    } wsh_result_t;

endpackage

FILE: rtl/wasm_section_header_scanner_core.sv
`timescale 1ns / 1ps

// Section header scanner for WebAssembly modules. Takes one module byte per
// request and sustains one byte per cycle while the result side is ready;
// a byte passes an input register, the combinational parse logic and a
// result register, which holds the report until it is taken. The
// single result register sets the rate: a report not taken stalls the byte
// behind it. Reports: bad magic at offset 3, one per section header (id,
// size, offsets, version, first match of the wanted id), and a size
// encoding too long, after which the module is ignored. Write the
// configuration registers only while no request is in flight.

module wasm_section_header_scanner_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wsh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsh_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    input  logic                           s_start_of_module,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_report_kind,
    output logic [7:0]                     m_section_id,
    output logic [31:0]                    m_section_size,
    output logic [wsh_pkg::POS_W-1:0]      m_header_offset,
    output logic [wsh_pkg::POS_W-1:0]      m_content_offset,
    output logic                           m_is_wanted,
    output logic [31:0]                    m_module_version
);
    import wsh_pkg::*;

    logic [7:0]       wanted_reg;
    logic [POS_W-1:0] limit_reg;

    wsh_item_t   s_item, item;
    logic        item_valid;
    logic        advance;
    logic        space;
    logic        res_valid;
    wsh_result_t res, m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_reg <= WANTED_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_WANTED_SECTION) wanted_reg <= cfg_wdata[7:0];
            if (cfg_index == CFG_MODULE_LIMIT)   limit_reg  <= cfg_wdata[POS_W-1:0];
        end
    end

    assign s_item  = {s_data_byte, s_start_of_module};
    assign advance = item_valid && space;

    wsh_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    wsh_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .item           (item),
        .wanted_section (wanted_reg),
        .module_limit   (limit_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    wsh_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res     (res),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_report_kind    = m_res.report_kind;
    assign m_section_id     = m_res.section_id;
    assign m_section_size   = m_res.section_size;
    assign m_header_offset  = m_res.header_offset;
    assign m_content_offset = m_res.content_offset;
    assign m_is_wanted      = m_res.is_wanted;
    assign m_module_version = m_res.module_version;

endmodule

FILE: rtl/wsh_in_reg.sv
`timescale 1ns / 1ps

module wsh_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wsh_pkg::wsh_item_t s_item,
    output logic               item_valid,
    output wsh_pkg::wsh_item_t item,
    input  logic               advance
);
    import wsh_pkg::*;

    logic      valid_reg;
    wsh_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: rtl/wsh_parser.sv
`timescale 1ns / 1ps

module wsh_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  wsh_pkg::wsh_item_t        item,
    input  logic [7:0]                wanted_section,
    input  logic [wsh_pkg::POS_W-1:0] module_limit,
    output logic                      res_valid,
    output wsh_pkg::wsh_result_t      res
);
    import wsh_pkg::*;

    wsh_phase_t       phase_reg, phase_next, phase_c;
    logic [POS_W-1:0] pos_reg, pos_next, pos_c;
    logic [7:0]       id_reg, id_next, id_c;
    logic [31:0]      acc_reg, acc_next, acc_c;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_c;
    logic [31:0]      skip_reg, skip_next, skip_c;
    logic             magic_good_reg, magic_good_next, magic_good_c;
    logic [31:0]      version_reg, version_next, version_c;
    logic             match_reg, match_next, match_c;
    logic [POS_W-1:0] hstart_reg, hstart_next, hstart_c;

    logic [7:0]       b;
    logic [SH_W-1:0]  shift_amt;
    logic [31:0]      acc_merged;
    logic [CNT_W-1:0] cnt_inc;
    logic             size_last;
    logic             size_too_long;
    logic             magic_ok;
    logic             hit;
    logic [POS_W-1:0] coff;

    assign b = item.data_byte;

    // clear module state ahead of a byte that opens a new module
    always_comb begin
        if (item.start_of_module) begin
            phase_c      = PH_MAGIC;
            pos_c        = '0;
            id_c         = '0;
            acc_c        = '0;
            cnt_c        = '0;
            skip_c       = '0;
            magic_good_c = 1'b1;
            version_c    = '0;
            match_c      = 1'b0;
            hstart_c     = '0;
        end else begin
            phase_c      = phase_reg;
            pos_c        = pos_reg;
            id_c         = id_reg;
            acc_c        = acc_reg;
            cnt_c        = cnt_reg;
            skip_c       = skip_reg;
            magic_good_c = magic_good_reg;
            version_c    = version_reg;
            match_c      = match_reg;
            hstart_c     = hstart_reg;
        end
    end

    assign shift_amt     = SH_W'(cnt_c) * SH_W'(LEB_BITS);
    assign acc_merged    = (shift_amt < SH_W'(32)) ?
                           (acc_c | ({25'b0, b[6:0]} << shift_amt)) : acc_c;
    assign cnt_inc       = cnt_c + CNT_W'(1);
    assign size_last     = !b[7];
    assign size_too_long = b[7] && (cnt_inc >= CNT_W'(MAX_SIZE_BYTES));
    assign magic_ok      = magic_good_c && (b == MAGIC[pos_c[1:0]]);
    assign hit           = !match_c && (id_c == wanted_section);
    assign coff          = (pos_c < POS_MAX) ? pos_c + POS_W'(1) : POS_MAX;

    always_comb begin
        phase_next = phase_c;
        unique case (phase_c)
            PH_MAGIC: begin
                if (pos_c >= POS_W'(3)) phase_next = PH_VERSION;
            end
            PH_VERSION: begin
                if (pos_c >= POS_W'(7)) phase_next = PH_ID;
            end
            PH_ID: begin
                phase_next = (pos_c >= module_limit) ? PH_STOP : PH_SIZE;
            end
            PH_SIZE: begin
                if (size_too_long) begin
                    phase_next = PH_STOP;
                end else if (size_last) begin
                    phase_next = (acc_merged != '0) ? PH_SKIP : PH_ID;
                end
            end
            PH_SKIP: begin
                if (skip_c == 32'd1) phase_next = PH_ID;
            end
            default: phase_next = phase_c;
        endcase
    end

    always_comb begin
        pos_next        = (pos_c < POS_MAX) ? pos_c + POS_W'(1) : pos_c;
        id_next         = id_c;
        acc_next        = acc_c;
        cnt_next        = cnt_c;
        skip_next       = skip_c;
        magic_good_next = magic_good_c;
        version_next    = version_c;
        match_next      = match_c;
        hstart_next     = hstart_c;
        unique case (phase_c)
            PH_MAGIC: begin
                magic_good_next = magic_ok;
            end
            PH_VERSION: begin
                version_next[8*pos_c[1:0] +: 8] = b;
            end
            PH_ID: begin
                if (pos_c < module_limit) begin
                    id_next     = b;
                    hstart_next = pos_c;
                    acc_next    = '0;
                    cnt_next    = '0;
                end
            end
            PH_SIZE: begin
                acc_next = acc_merged;
                cnt_next = cnt_inc;
                if (size_last) begin
                    skip_next = acc_merged;
                    if (hit) match_next = 1'b1;
                end
            end
            PH_SKIP: begin
                skip_next = skip_c - 32'd1;
            end
            default: ;
        endcase
    end

    always_comb begin
        res_valid          = 1'b0;
        res.report_kind    = KIND_HEADER;
        res.section_id     = '0;
        res.section_size   = '0;
        res.header_offset  = '0;
        res.content_offset = '0;
        res.is_wanted      = 1'b0;
        res.module_version = '0;
        unique case (phase_c)
            PH_MAGIC: begin
                if (pos_c >= POS_W'(3) && !magic_ok) begin
                    res_valid       = 1'b1;
                    res.report_kind = KIND_BAD_MAGIC;
                end
            end
            PH_SIZE: begin
                if (size_too_long || size_last) begin
                    res_valid          = 1'b1;
                    res.report_kind    = size_last ? KIND_HEADER : KIND_SIZE_TOO_LONG;
                    res.section_id     = id_c;
                    res.section_size   = acc_merged;
                    res.header_offset  = hstart_c;
                    res.content_offset = size_last ? coff : '0;
                    res.is_wanted      = size_last && hit;
                    res.module_version = version_c;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_MAGIC;
            pos_reg        <= '0;
            id_reg         <= '0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            skip_reg       <= '0;
            magic_good_reg <= 1'b1;
            version_reg    <= '0;
            match_reg      <= 1'b0;
            hstart_reg     <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            id_reg         <= id_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            skip_reg       <= skip_next;
            magic_good_reg <= magic_good_next;
            version_reg    <= version_next;
            match_reg      <= match_next;
            hstart_reg     <= hstart_next;
        end
    end

endmodule

FILE: rtl/wsh_out_reg.sv
`timescale 1ns / 1ps

module wsh_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  wsh_pkg::wsh_result_t res,
    output logic                 space,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wsh_pkg::wsh_result_t m_res
);
    import wsh_pkg::*;

    logic        valid_reg;
    wsh_result_t res_reg;

    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

FILE: rtl/wsh_checker.sv
`timescale 1ns / 1ps

module wsh_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [1:0]                     m_report_kind,
    input logic [7:0]                     m_section_id,
    input logic [31:0]                    m_section_size,
    input logic [wsh_pkg::POS_W-1:0]      m_header_offset,
    input logic [wsh_pkg::POS_W-1:0]      m_content_offset,
    input logic                           m_is_wanted,
    input logic [31:0]                    m_module_version
);
    import wsh_pkg::*;

    // hold a stalled report
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_report_kind) &&
        $stable(m_section_size) && $stable(m_header_offset) &&
        $stable(m_content_offset))
        else $error("stalled report changed");

    a_bad_magic_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_report_kind == KIND_BAD_MAGIC |->
        m_section_id == 8'd0 && m_section_size == 32'd0 &&
        m_header_offset == '0 && m_content_offset == '0 &&
        !m_is_wanted && m_module_version == 32'd0)
        else $error("bad magic report carries data");

    a_too_long_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_report_kind == KIND_SIZE_TOO_LONG |->
        m_content_offset == '0 && !m_is_wanted)
        else $error("size too long report carries content offset or match");

    a_header_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_report_kind == KIND_HEADER |->
        m_content_offset > m_header_offset)
        else $error("content offset not past header offset");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_report_kind != 2'd3)
        else $error("undefined report kind");

endmodule

bind wasm_section_header_scanner_core wsh_checker u_wsh_checker (.*);

FILE: sim/wasm_section_header_scanner_core_test.sv
`timescale 1ns / 1ps

module wasm_section_header_scanner_core_test;
    import wsh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int ROUND_BYTES    = 20;

    localparam logic [7:0]       WASM_MAGIC [4] = '{8'h00, 8'h61, 8'h73, 8'h6d};
    localparam logic [POS_W-1:0] OFFSET_MAX     = {POS_W{1'b1}};
    localparam logic [7:0]       RESET_WANTED   = 8'd1;
    localparam logic [POS_W-1:0] RESET_LIMIT    = 24'd1024000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                  aclk              = 1'b0;
    logic                  aresetn           = 1'b0;
    logic                  cfg_wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index         = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata         = '0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte       = '0;
    logic                  s_start_of_module = 1'b0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic [1:0]            m_report_kind;
    logic [7:0]            m_section_id;
    logic [31:0]           m_section_size;
    logic [POS_W-1:0]      m_header_offset;
    logic [POS_W-1:0]      m_content_offset;
    logic                  m_is_wanted;
    logic [31:0]           m_module_version;

    wasm_section_header_scanner_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_start_of_module (s_start_of_module),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_report_kind     (m_report_kind),
        .m_section_id      (m_section_id),
        .m_section_size    (m_section_size),
        .m_header_offset   (m_header_offset),
        .m_content_offset  (m_content_offset),
        .m_is_wanted       (m_is_wanted),
        .m_module_version  (m_module_version)
    );

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;
    int bytes_sent     = 0;
    int modules_sent   = 0;
    int reports_seen   = 0;
    int wanted_seen    = 0;
    int bad_magic_seen = 0;
    int too_long_seen  = 0;

    wsh_result_t report_q [$];

    logic [7:0]       want_id;
    logic [POS_W-1:0] scan_limit;
    wsh_phase_t       scan_phase;
    logic [POS_W-1:0] scan_pos;
    logic [7:0]       scan_id;
    logic [31:0]      size_acc;
    int unsigned      size_bytes;
    logic [31:0]      skip_left;
    bit               magic_ok;
    logic [31:0]      version_word;
    bit               wanted_found;
    logic [POS_W-1:0] header_pos;

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void clear_scan();
        scan_phase   = PH_MAGIC;
        scan_pos     = '0;
        scan_id      = '0;
        size_acc     = '0;
        size_bytes   = 0;
        skip_left    = '0;
        magic_ok     = 1'b1;
        version_word = '0;
        wanted_found = 1'b0;
        header_pos   = '0;
    endfunction

    function automatic void scan_byte(input logic [7:0] b, input logic som);
        wsh_result_t      r;
        bit               hit;
        int unsigned      shift;
        logic [POS_W-1:0] p;
        r   = '0;
        hit = 1'b0;
        if (som) clear_scan();
        p = scan_pos;
        case (scan_phase)
            PH_MAGIC: begin
                if (b != WASM_MAGIC[p[1:0]]) magic_ok = 1'b0;
                if (p >= 3) begin
                    scan_phase = PH_VERSION;
                    if (!magic_ok) begin
                        r.report_kind = KIND_BAD_MAGIC;
                        hit = 1'b1;
                    end
                end
            end
            PH_VERSION: begin
                version_word[8 * p[1:0] +: 8] = b;
                if (p >= 7) scan_phase = PH_ID;
            end
            PH_ID: begin
                if (p >= scan_limit) begin
                    scan_phase = PH_STOP;
                end else begin
                    scan_id    = b;
                    header_pos = p;
                    size_acc   = '0;
                    size_bytes = 0;
                    scan_phase = PH_SIZE;
                end
            end
            PH_SIZE: begin
                shift = 7 * size_bytes;
                if (shift < 32) size_acc |= 32'(b[6:0]) << shift;
                size_bytes++;
                r.section_id     = scan_id;
                r.section_size   = size_acc;
                r.header_offset  = header_pos;
                r.module_version = version_word;
                if (b[7]) begin
                    if (size_bytes >= MAX_SIZE_BYTES) begin
                        r.report_kind = KIND_SIZE_TOO_LONG;
                        hit = 1'b1;
                        scan_phase = PH_STOP;
                    end
                end else begin
                    r.report_kind    = KIND_HEADER;
                    r.content_offset = (p < OFFSET_MAX) ? p + 1'b1 : OFFSET_MAX;
                    if (!wanted_found && scan_id == want_id) begin
                        r.is_wanted  = 1'b1;
                        wanted_found = 1'b1;
                    end
                    hit = 1'b1;
                    skip_left  = size_acc;
                    scan_phase = (size_acc != 0) ? PH_SKIP : PH_ID;
                end
            end
            PH_SKIP: begin
                skip_left--;
                if (skip_left == 0) scan_phase = PH_ID;
            end
            default: ;
        endcase
        if (scan_pos != OFFSET_MAX) scan_pos++;
        if (hit) report_q.push_back(r);
    endfunction

    always @(posedge aclk) begin : check_reports
        wsh_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (report_q.size() == 0) begin
                err_count++;
                $error("unexpected report: kind %0d id %0d header_offset %0d",
                       m_report_kind, m_section_id, m_header_offset);
            end else begin
                exp_r = report_q.pop_front();
                if (m_report_kind !== exp_r.report_kind) begin
                    err_count++;
                    $error("report_kind: expected %0d, got %0d", exp_r.report_kind,
                           m_report_kind);
                end
                if (m_section_id !== exp_r.section_id) begin
                    err_count++;
                    $error("section_id: expected %0d, got %0d", exp_r.section_id,
                           m_section_id);
                end
                if (m_section_size !== exp_r.section_size) begin
                    err_count++;
                    $error("section_size: expected %0d, got %0d", exp_r.section_size,
                           m_section_size);
                end
                if (m_header_offset !== exp_r.header_offset) begin
                    err_count++;
                    $error("header_offset: expected %0d, got %0d", exp_r.header_offset,
                           m_header_offset);
                end
                if (m_content_offset !== exp_r.content_offset) begin
                    err_count++;
                    $error("content_offset: expected %0d, got %0d", exp_r.content_offset,
                           m_content_offset);
                end
                if (m_is_wanted !== exp_r.is_wanted) begin
                    err_count++;
                    $error("is_wanted: expected %0d, got %0d", exp_r.is_wanted,
                           m_is_wanted);
                end
                if (m_module_version !== exp_r.module_version) begin
                    err_count++;
                    $error("module_version: expected %h, got %h", exp_r.module_version,
                           m_module_version);
                end
                wanted_seen += exp_r.is_wanted;
                if (exp_r.report_kind == KIND_BAD_MAGIC) bad_magic_seen++;
                if (exp_r.report_kind == KIND_SIZE_TOO_LONG) too_long_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("wasm_section_header_scanner_core test failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic som);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_data_byte       <= b;
        s_start_of_module <= som;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_byte(b, som);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_WANTED_SECTION) want_id = val[7:0];
        else if (idx == CFG_MODULE_LIMIT) scan_limit = val[POS_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_size(input logic [31:0] value, input int unsigned pad, input bit spill);
        int unsigned n_bytes;
        logic [31:0] rest;
        logic [7:0]  chunk;
        n_bytes = 1;
        rest    = value >> 7;
        while (rest != 0) begin
            n_bytes++;
            rest = rest >> 7;
        end
        n_bytes += pad;
        if (spill || n_bytes > MAX_SIZE_BYTES) n_bytes = MAX_SIZE_BYTES;
        for (int i = 0; i < n_bytes; i++) begin
            chunk = {1'b0, 7'(value >> (7 * i))};
            // bits above 31 in the last group fall off the word
            if (spill && i == MAX_SIZE_BYTES - 1) chunk[6:4] = 3'($urandom_range(1, 7));
            chunk[7] = (i < n_bytes - 1);
            send_byte(chunk, 1'b0);
        end
    endtask

    task automatic send_section(input bit cut, output bit stopped);
        logic [7:0]  id;
        logic [31:0] size;
        int unsigned roll;
        int unsigned n_content;
        stopped = 1'b0;
        roll = $urandom_range(99);
        id = (roll < 20) ? want_id : (roll < 60) ? 8'($urandom_range(12)) : 8'($urandom);
        roll = $urandom_range(99);
        size = (roll < 70) ? $urandom_range(4) :
               (roll < 90) ? $urandom_range(5, 40) : $urandom_range(128, 160);
        send_byte(id, 1'b0);
        if ($urandom_range(24) == 0) begin
            repeat (MAX_SIZE_BYTES) send_byte(8'h80 | 8'($urandom), 1'b0);
            stopped = 1'b1;
            return;
        end
        send_size(size, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0,
                  $urandom_range(19) == 0);
        n_content = cut ? $urandom_range(size) : size;
        repeat (n_content) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_module();
        logic [7:0]  head [8];
        logic [31:0] ver;
        int unsigned n_sec;
        bit          cut;
        bit          stopped;
        ver = $urandom;
        for (int i = 0; i < 4; i++) begin
            head[i]     = WASM_MAGIC[i];
            head[i + 4] = ver[8 * i +: 8];
        end
        if ($urandom_range(7) == 0) head[$urandom_range(3)] = 8'($urandom);
        for (int i = 0; i < 8; i++) send_byte(head[i], i == 0);
        n_sec   = $urandom_range(1, 6);
        cut     = ($urandom_range(9) == 0);
        stopped = 1'b0;
        for (int i = 0; i < n_sec && !stopped; i++) send_section(cut && i == n_sec - 1, stopped);
        modules_sent++;
    endtask

    task automatic test_first_module_after_reset();
        logic [7:0] stream [20];
        stream = '{8'h00, 8'h61, 8'h73, 8'h6d, 8'hff, 8'h00, 8'h00, 8'h80,
                   8'h01, 8'h01, 8'haa, 8'h01, 8'h00,
                   8'h0b, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00};
        foreach (stream[i]) send_byte(stream[i], 1'b0);
    endtask

    task automatic test_bad_magic_new_module();
        logic [7:0] stream [10];
        stream = '{8'h6d, 8'h73, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
        foreach (stream[i]) send_byte(stream[i], i == 0);
    endtask

    task automatic test_register_writes();
        wait_drain();
        write_reg(CFG_WANTED_SECTION, {CFG_DATA_W{1'b1}});
        write_reg(CFG_MODULE_LIMIT, '0);
        write_reg(CFG_SPARE_LO, 24'h000123);
        write_reg(CFG_SPARE_HI, {CFG_DATA_W{1'b1}});
        send_module();
        wait_drain();
        write_reg(CFG_WANTED_SECTION, '0);
        write_reg(CFG_MODULE_LIMIT, OFFSET_MAX);
        send_module();
        wait_drain();
        write_reg(CFG_MODULE_LIMIT, 24'd8);
        send_module();
        wait_drain();
        write_reg(CFG_MODULE_LIMIT, 24'd9);
        send_module();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int round = 0; round < 3; round++) begin
            wait_drain();
            write_reg(CFG_WANTED_SECTION, $urandom_range(1) ? 24'($urandom_range(12))
                                                            : 24'($urandom));
            write_reg(CFG_MODULE_LIMIT, (round == 2) ? 24'($urandom_range(8, 60)) :
                                        $urandom_range(1) ? OFFSET_MAX :
                                        24'($urandom_range(200, 5000)));
            goal = bytes_sent + ROUND_BYTES;
            while (bytes_sent < goal) begin
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(3, 20))
                        send_byte(8'($urandom), $urandom_range(3) == 0);
                end else begin
                    send_module();
                end
                // hold off until every report is back
                if ($urandom_range(15) == 0) wait_drain();
            end
        end
    endtask

    initial begin
        want_id    = RESET_WANTED;
        scan_limit = RESET_LIMIT;
        clear_scan();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_first_module_after_reset();
        test_bad_magic_new_module();
        test_register_writes();
        test_random_traffic(9, 61);
        test_random_traffic(61, 9);
        test_random_traffic(0, 0);
        wait_drain();
        repeat (10) @(posedge aclk);
        if (report_q.size() != 0) begin
            err_count++;
            $error("%0d expected reports never arrived", report_q.size());
        end
        $display("Covered %0d bytes over %0d modules, %0d reports checked", bytes_sent,
                 modules_sent, reports_seen);
        $display("  (%0d wanted, %0d bad magic, %0d size too long) under three stall mixes",
                 wanted_seen, bad_magic_seen, too_long_seen);
        if (err_count == 0) begin
            $display("wasm_section_header_scanner_core test passed");
        end else begin
            $display("wasm_section_header_scanner_core test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/wsh_pkg.sv
rtl/wsh_in_reg.sv
rtl/wsh_parser.sv
rtl/wsh_out_reg.sv
rtl/wasm_section_header_scanner_core.sv
rtl/wsh_checker.sv
sim/wasm_section_header_scanner_core_test.sv
